// ===== sv/ijs_pkg.sv =====
// ----------------------------------------------------------------------------
// ijs_pkg
// Shared constants, types and the controller/datapath command bundle of the
// interval jitter statistics block.
// ----------------------------------------------------------------------------
package ijs_pkg;

  localparam int MAX_SAMPLES = 128;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  localparam int SC_W   = 8;
  localparam int SEC_W  = 32;
  localparam int NS_W   = 30;
  localparam int IV_W   = 31;
  localparam int VAR_W  = 62;
  localparam int STD_W  = 31;
  localparam int REL_W  = 32;
  localparam int SUM_W  = IV_W + ADDR_W;
  localparam int ACC_W  = 2 * IV_W + ADDR_W;
  localparam int SCL_W  = 14;
  localparam int PROD_W = STD_W + SCL_W;
  localparam int DVD_W  = (ACC_W > PROD_W) ? ACC_W : PROD_W;
  localparam int DCNT_W = $clog2(DVD_W);
  localparam int SQ_STEPS = VAR_W / 2;
  localparam int SQCNT_W  = $clog2(SQ_STEPS);

  localparam logic [SC_W-1:0]  SAMPLE_COUNT_RESET = 8'd100;
  localparam logic [31:0]      NS_PER_SEC         = 32'd1000000000;
  localparam logic [SCL_W-1:0] REL_SCALE          = 14'd10000;

  typedef enum logic [1:0] {
    SEL_MEAN = 2'd0,
    SEL_VAR  = 2'd1,
    SEL_REL  = 2'd2
  } ijs_div_sel_e;

  typedef struct packed {
    logic         accept;
    logic         walk_start;
    logic         walk_en;
    logic         pass2;
    logic         div_start;
    ijs_div_sel_e div_sel;
    logic         sqrt_start;
    logic         mul_load;
    logic         rel_sat;
    logic         finish;
  } ijs_cmd_t;

  typedef struct packed {
    logic close_next;
    logic walk_done;
    logic div_done;
    logic sqrt_done;
    logic mean_zero;
  } ijs_sts_t;

  typedef struct packed {
    logic [IV_W-1:0]  min_interval;
    logic [IV_W-1:0]  max_interval;
    logic [IV_W-1:0]  mean_interval;
    logic [VAR_W-1:0] variance_value;
    logic [STD_W-1:0] std_deviation;
    logic [REL_W-1:0] relative_deviation;
    logic             mean_was_zero;
  } ijs_result_t;

endpackage

// ===== sv/ijs_if.sv =====
// ----------------------------------------------------------------------------
// ijs_if
// Valid/ready channels for timestamps in and statistics results out.
// ----------------------------------------------------------------------------
interface ijs_in_if;
  logic                       valid;
  logic                       ready;
  logic [ijs_pkg::SEC_W-1:0]  tick_seconds;
  logic [ijs_pkg::NS_W-1:0]   tick_nanoseconds;
  modport source (output valid, output tick_seconds, output tick_nanoseconds, input ready);
  modport sink   (input valid, input tick_seconds, input tick_nanoseconds, output ready);
endinterface

interface ijs_out_if;
  logic                       valid;
  logic                       ready;
  logic [ijs_pkg::IV_W-1:0]   min_interval;
  logic [ijs_pkg::IV_W-1:0]   max_interval;
  logic [ijs_pkg::IV_W-1:0]   mean_interval;
  logic [ijs_pkg::VAR_W-1:0]  variance_value;
  logic [ijs_pkg::STD_W-1:0]  std_deviation;
  logic [ijs_pkg::REL_W-1:0]  relative_deviation;
  logic                       mean_was_zero;
  modport source (output valid, output min_interval, output max_interval,
                  output mean_interval, output variance_value, output std_deviation,
                  output relative_deviation, output mean_was_zero, input ready);
  modport sink   (input valid, input min_interval, input max_interval,
                  input mean_interval, input variance_value, input std_deviation,
                  input relative_deviation, input mean_was_zero, output ready);
endinterface

// ===== sv/ijs_div.sv =====
// ----------------------------------------------------------------------------
// ijs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ijs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ijs_pkg::DVD_W-1:0]  dividend_i,
  input  logic [ijs_pkg::IV_W-1:0]   divisor_i,
  output logic                       done_o,
  output logic [ijs_pkg::DVD_W-1:0]  quotient_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [ijs_pkg::DCNT_W-1:0]  cnt_q;
  logic [ijs_pkg::DVD_W-1:0]   a_q;
  logic [ijs_pkg::IV_W-1:0]    r_q;
  logic [ijs_pkg::IV_W-1:0]    d_q;
  logic [ijs_pkg::IV_W:0]      t;
  logic [ijs_pkg::IV_W:0]      diff;
  logic                        ge;

  always_comb begin
    t    = {r_q, a_q[ijs_pkg::DVD_W-1]};
    diff = t - {1'b0, d_q};
    ge   = (t >= {1'b0, d_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ijs_pkg::DCNT_W'(ijs_pkg::DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      a_q <= {a_q[ijs_pkg::DVD_W-2:0], ge};
      r_q <= ge ? diff[ijs_pkg::IV_W-1:0] : t[ijs_pkg::IV_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = a_q;

endmodule

// ===== sv/ijs_sqrt.sv =====
// ----------------------------------------------------------------------------
// ijs_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ijs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ijs_pkg::VAR_W-1:0]   value_i,
  output logic                        done_o,
  output logic [ijs_pkg::STD_W-1:0]   root_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [ijs_pkg::SQCNT_W-1:0]  cnt_q;
  logic [ijs_pkg::VAR_W-1:0]    v_q;
  logic [ijs_pkg::STD_W-1:0]    root_q;
  logic [ijs_pkg::STD_W+1:0]    rem_q;
  logic [ijs_pkg::STD_W+3:0]    t;
  logic [ijs_pkg::STD_W+3:0]    trial;
  logic [ijs_pkg::STD_W+3:0]    diff;
  logic                         ge;

  always_comb begin
    t     = {rem_q, v_q[ijs_pkg::VAR_W-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    diff  = t - trial;
    ge    = (t >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == ijs_pkg::SQCNT_W'(ijs_pkg::SQ_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= value_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      v_q    <= {v_q[ijs_pkg::VAR_W-3:0], 2'b00};
      root_q <= {root_q[ijs_pkg::STD_W-2:0], ge};
      rem_q  <= ge ? diff[ijs_pkg::STD_W+1:0] : t[ijs_pkg::STD_W+1:0];
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== sv/ijs_datapath.sv =====
// ----------------------------------------------------------------------------
// ijs_datapath
// Interval capture, interval store, statistics walk and arithmetic units.
// ----------------------------------------------------------------------------
module ijs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ijs_pkg::SC_W-1:0]    cfg_wdata_i,
  input  logic [ijs_pkg::SEC_W-1:0]   tick_seconds_i,
  input  logic [ijs_pkg::NS_W-1:0]    tick_nanoseconds_i,
  input  ijs_pkg::ijs_cmd_t           cmd_i,
  output ijs_pkg::ijs_sts_t           sts_o,
  output ijs_pkg::ijs_result_t        res_o
);

  logic [ijs_pkg::SC_W-1:0]   sample_count_q;
  logic [ijs_pkg::CNT_W-1:0]  n_eff;
  logic [ijs_pkg::SEC_W-1:0]  prev_sec_q;
  logic [ijs_pkg::NS_W-1:0]   prev_ns_q;
  logic                       have_prev_q;
  logic [ijs_pkg::CNT_W-1:0]  cnt_q;
  logic [ijs_pkg::CNT_W-1:0]  cnt_after;
  logic [ijs_pkg::ADDR_W-1:0] wr_idx;
  logic signed [32:0]         iv_s;
  logic [ijs_pkg::IV_W-1:0]   iv;
  logic                       wr_en;

  logic [ijs_pkg::IV_W-1:0]   mem [ijs_pkg::MAX_SAMPLES];
  logic [ijs_pkg::IV_W-1:0]   rd_data_q;
  logic [ijs_pkg::CNT_W-1:0]  idx_q;
  logic                       issue;
  logic                       rd_vld_q;
  logic                       d_vld_q;
  logic                       s_vld_q;
  logic                       first_q;

  logic [ijs_pkg::IV_W-1:0]   min_q;
  logic [ijs_pkg::IV_W-1:0]   max_q;
  logic [ijs_pkg::SUM_W-1:0]  sum_q;
  logic [ijs_pkg::IV_W-1:0]   mean_q;
  logic [ijs_pkg::IV_W-1:0]   diff_q;
  logic [ijs_pkg::VAR_W-1:0]  sq_q;
  logic [ijs_pkg::ACC_W-1:0]  acc_q;
  logic [ijs_pkg::VAR_W-1:0]  var_q;
  logic [ijs_pkg::STD_W-1:0]  sd_q;
  logic [ijs_pkg::PROD_W-1:0] prod_q;
  logic [ijs_pkg::REL_W-1:0]  rel_q;
  logic                       zero_q;

  logic [ijs_pkg::DVD_W-1:0]  div_dvd;
  logic [ijs_pkg::IV_W-1:0]   div_dvs;
  logic                       div_done;
  logic [ijs_pkg::DVD_W-1:0]  div_q;
  logic                       sqrt_done;
  logic [ijs_pkg::STD_W-1:0]  sqrt_root;

  // window size clamp
  always_comb begin
    if (32'(sample_count_q) < 32'd2) begin
      n_eff = ijs_pkg::CNT_W'(2);
    end else if (32'(sample_count_q) > 32'(ijs_pkg::MAX_SAMPLES)) begin
      n_eff = ijs_pkg::CNT_W'(ijs_pkg::MAX_SAMPLES);
    end else begin
      n_eff = ijs_pkg::CNT_W'(sample_count_q);
    end
  end

  always_comb begin
    iv_s = $signed({3'b000, tick_nanoseconds_i}) - $signed({3'b000, prev_ns_q});
    if (tick_seconds_i != prev_sec_q) begin
      iv_s = iv_s + $signed({1'b0, ijs_pkg::NS_PER_SEC});
    end
    iv = iv_s[32] ? '0 : iv_s[ijs_pkg::IV_W-1:0];
    if (32'(cnt_q) >= 32'(ijs_pkg::MAX_SAMPLES)) begin
      wr_idx    = ijs_pkg::ADDR_W'(ijs_pkg::MAX_SAMPLES - 1);
      cnt_after = ijs_pkg::CNT_W'(ijs_pkg::MAX_SAMPLES);
    end else begin
      wr_idx    = cnt_q[ijs_pkg::ADDR_W-1:0];
      cnt_after = cnt_q + 1'b1;
    end
    wr_en = cmd_i.accept && have_prev_q;
    issue = cmd_i.walk_en && (idx_q != cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= ijs_pkg::SAMPLE_COUNT_RESET;
      prev_sec_q     <= '0;
      prev_ns_q      <= '0;
      have_prev_q    <= 1'b0;
      cnt_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        sample_count_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        prev_sec_q  <= tick_seconds_i;
        prev_ns_q   <= tick_nanoseconds_i;
        have_prev_q <= 1'b1;
        if (have_prev_q) begin
          cnt_q <= cnt_after;
        end
      end else if (cmd_i.finish) begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= iv;
    end
    rd_data_q <= mem[idx_q[ijs_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      d_vld_q  <= 1'b0;
      s_vld_q  <= 1'b0;
      first_q  <= 1'b0;
    end else if (cmd_i.walk_start) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      d_vld_q  <= 1'b0;
      s_vld_q  <= 1'b0;
      first_q  <= 1'b1;
    end else begin
      rd_vld_q <= issue;
      if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
      d_vld_q <= rd_vld_q && cmd_i.pass2;
      s_vld_q <= d_vld_q;
      if (rd_vld_q) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && !cmd_i.pass2) begin
      if (first_q) begin
        min_q <= rd_data_q;
        max_q <= rd_data_q;
        sum_q <= ijs_pkg::SUM_W'(rd_data_q);
      end else begin
        if (rd_data_q < min_q) min_q <= rd_data_q;
        if (rd_data_q > max_q) max_q <= rd_data_q;
        sum_q <= sum_q + ijs_pkg::SUM_W'(rd_data_q);
      end
    end
    diff_q <= (rd_data_q >= mean_q) ? (rd_data_q - mean_q) : (mean_q - rd_data_q);
    sq_q   <= ijs_pkg::VAR_W'(diff_q) * ijs_pkg::VAR_W'(diff_q);
    if (cmd_i.walk_start) begin
      acc_q <= '0;
    end else if (s_vld_q) begin
      acc_q <= acc_q + ijs_pkg::ACC_W'(sq_q);
    end
    if (div_done) begin
      case (cmd_i.div_sel)
        ijs_pkg::SEL_MEAN: mean_q <= div_q[ijs_pkg::IV_W-1:0];
        ijs_pkg::SEL_VAR:  var_q  <= div_q[ijs_pkg::VAR_W-1:0];
        ijs_pkg::SEL_REL:  rel_q  <= (|div_q[ijs_pkg::DVD_W-1:ijs_pkg::REL_W]) ?
                                     '1 : div_q[ijs_pkg::REL_W-1:0];
        default: ;
      endcase
    end else if (cmd_i.rel_sat) begin
      rel_q <= '1;
    end
    if (sqrt_done) begin
      sd_q <= sqrt_root;
    end
    if (cmd_i.mul_load) begin
      prod_q <= ijs_pkg::PROD_W'(sd_q) * ijs_pkg::PROD_W'(ijs_pkg::REL_SCALE);
      zero_q <= (mean_q == '0);
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      ijs_pkg::SEL_VAR: begin
        div_dvd = ijs_pkg::DVD_W'(acc_q);
        div_dvs = ijs_pkg::IV_W'(cnt_q);
      end
      ijs_pkg::SEL_REL: begin
        div_dvd = ijs_pkg::DVD_W'(prod_q);
        div_dvs = mean_q;
      end
      default: begin
        div_dvd = ijs_pkg::DVD_W'(sum_q);
        div_dvs = ijs_pkg::IV_W'(cnt_q);
      end
    endcase
  end

  ijs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  ijs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (var_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_comb begin
    sts_o.close_next = have_prev_q && (cnt_after >= n_eff);
    sts_o.walk_done  = !rd_vld_q && !d_vld_q && !s_vld_q && (idx_q == cnt_q);
    sts_o.div_done   = div_done;
    sts_o.sqrt_done  = sqrt_done;
    sts_o.mean_zero  = zero_q;
    res_o.min_interval       = min_q;
    res_o.max_interval       = max_q;
    res_o.mean_interval      = mean_q;
    res_o.variance_value     = var_q;
    res_o.std_deviation      = sd_q;
    res_o.relative_deviation = rel_q;
    res_o.mean_was_zero      = zero_q;
  end

endmodule

// ===== sv/ijs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ijs_ctrl
// Sequencer for collection, the two store walks and the result arithmetic.
// ----------------------------------------------------------------------------
module ijs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ijs_pkg::ijs_sts_t   sts_i,
  output ijs_pkg::ijs_cmd_t   cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SUM    = 11'b000_0000_0010,
    S_MDIV   = 11'b000_0000_0100,
    S_VAR    = 11'b000_0000_1000,
    S_VDIV   = 11'b000_0001_0000,
    S_SQST   = 11'b000_0010_0000,
    S_SQRT   = 11'b000_0100_0000,
    S_MUL    = 11'b000_1000_0000,
    S_RSTART = 11'b001_0000_0000,
    S_RDIV   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } ijs_state_e;

  ijs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       ready;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.div_sel = ijs_pkg::SEL_MEAN;
    ready       = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        ready = !(out_valid_q && sts_i.close_next);
        if (ready && in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.close_next) begin
            cmd_o.walk_start = 1'b1;
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        cmd_o.walk_en = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.div_start = 1'b1;
          state_d = S_MDIV;
        end
      end
      S_MDIV: begin
        if (sts_i.div_done) begin
          cmd_o.walk_start = 1'b1;
          state_d = S_VAR;
        end
      end
      S_VAR: begin
        cmd_o.walk_en = 1'b1;
        cmd_o.pass2   = 1'b1;
        cmd_o.div_sel = ijs_pkg::SEL_VAR;
        if (sts_i.walk_done) begin
          cmd_o.div_start = 1'b1;
          state_d = S_VDIV;
        end
      end
      S_VDIV: begin
        cmd_o.pass2   = 1'b1;
        cmd_o.div_sel = ijs_pkg::SEL_VAR;
        if (sts_i.div_done) begin
          state_d = S_SQST;
        end
      end
      S_SQST: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (sts_i.sqrt_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d = S_RSTART;
      end
      S_RSTART: begin
        cmd_o.div_sel = ijs_pkg::SEL_REL;
        if (sts_i.mean_zero) begin
          cmd_o.rel_sat = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd_o.div_sel = ijs_pkg::SEL_REL;
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = ready;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("input ready outside idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised without completed computation");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_MDIV || state_q == S_VDIV || state_q == S_RDIV))
    else $error("divider finished outside a divide step");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !out_valid_q)
    else $error("new result while previous one pending");
`endif

endmodule

// ===== sv/interval_jitter_statistics.sv =====
// ----------------------------------------------------------------------------
// interval_jitter_statistics
// Timestamp interval statistics: min, max, mean, variance, std, relative dev.
// ----------------------------------------------------------------------------
// Timestamps are taken one per cycle while a window fills. The timestamp that
// closes a window of n intervals starts a statistics run (a min/max/sum walk
// of the interval store, a squared-deviation walk, up to three divisions on
// the shared one-bit-per-cycle divider and a square root), during which no
// timestamp is taken. The store walks run at one entry per cycle through its
// single read port. A finished result waits in the output register while the
// next window fills; only the timestamp that would close that window waits for
// it to be taken.
module interval_jitter_statistics (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ijs_pkg::SC_W-1:0]  cfg_wdata_i,
  ijs_in_if.sink                    in_i,
  ijs_out_if.source                 out_o
);

  ijs_pkg::ijs_cmd_t    cmd;
  ijs_pkg::ijs_sts_t    sts;
  ijs_pkg::ijs_result_t res;

  ijs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ijs_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .tick_seconds_i     (in_i.tick_seconds),
    .tick_nanoseconds_i (in_i.tick_nanoseconds),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .res_o              (res)
  );

  assign out_o.min_interval       = res.min_interval;
  assign out_o.max_interval       = res.max_interval;
  assign out_o.mean_interval      = res.mean_interval;
  assign out_o.variance_value     = res.variance_value;
  assign out_o.std_deviation      = res.std_deviation;
  assign out_o.relative_deviation = res.relative_deviation;
  assign out_o.mean_was_zero      = res.mean_was_zero;

endmodule
